### rtl/dgr_pkg.sv
// ----------------------------------------------------------------------------
// dgr_pkg: shared types for the graph reachability table
// Operation and status codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package dgr_pkg;

  localparam int unsigned INIT_COUNT = 9;
  // width that holds any node number or count up to 256
  localparam int unsigned CMPW = 9;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_TRAVEL = 2'd2,
    OP_RESIZE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED    = 3'd0,
    ST_DUPLICATE   = 3'd1,
    ST_RANGE       = 3'd2,
    ST_DELETED     = 3'd3,
    ST_NO_EDGE     = 3'd4,
    ST_REACHABLE   = 3'd5,
    ST_UNREACHABLE = 3'd6,
    ST_RESIZED     = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ROW,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic cap;        // capture input transfer
    logic decode;     // range check, resize
    logic rd_row;     // read source row
    logic rd_sweep;   // read row at sweep index
    logic row_op;     // insert/delete on the row just read
    logic trav_init;  // reached set <= source row
    logic acc;        // merge the row just read into the reached set
    logic pass_clr;   // start a new closure pass
    logic trav_done;  // status from reached set
    logic out_load;   // move status into the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_ok;      // non-resize op with both nodes in range
    logic is_travel;
    logic changed;    // reached set grew during this pass
    logic out_free;
  } sts_t;

endpackage

### rtl/dgr_ram.sv
// ----------------------------------------------------------------------------
// dgr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dgr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/dgr_ctrl.sv
// ----------------------------------------------------------------------------
// dgr_ctrl: operation sequencer
// Steps each operation through decode, row access and the closure sweeps.
// ----------------------------------------------------------------------------
module dgr_ctrl #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  dgr_pkg::sts_t                sts_i,
  output dgr_pkg::cmd_t                cmd_o,
  output logic [$clog2(MAX_NODES)-1:0] sweep_idx_o
);
  import dgr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam logic [AW-1:0] LAST_IDX = AW'(MAX_NODES - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;

  // next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = sts_i.in_ok ? S_ROW : S_DONE;
      end
      S_ROW: begin
        if (sts_i.is_travel) begin
          state_d = S_SWEEP;
          idx_d   = '0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SWEEP: begin
        idx_d = idx_q + AW'(1);
        if (idx_q == LAST_IDX) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts_i.changed) begin
          state_d = S_SWEEP;
          idx_d   = '0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.cap  = in_valid_i;
      end
      S_DECODE: begin
        cmd_o.decode = 1'b1;
        cmd_o.rd_row = sts_i.in_ok;
      end
      S_ROW: begin
        cmd_o.trav_init = sts_i.is_travel;
        cmd_o.row_op    = !sts_i.is_travel;
      end
      S_SWEEP: begin
        cmd_o.rd_sweep = 1'b1;
        cmd_o.acc      = (idx_q != '0);
      end
      S_DRAIN: begin
        cmd_o.acc       = 1'b1;
        cmd_o.pass_clr  = sts_i.changed;
        cmd_o.trav_done = !sts_i.changed;
      end
      S_DONE: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign sweep_idx_o = idx_q;

endmodule

### rtl/dgr_dpath.sv
// ----------------------------------------------------------------------------
// dgr_dpath: edge matrix, node count, reached set and result register
// Edge rows live in a RAM; per-row valid bits stand for cleared rows.
// ----------------------------------------------------------------------------
module dgr_dpath #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dgr_pkg::cmd_t                cmd_i,
  input  logic [$clog2(MAX_NODES)-1:0] sweep_idx_i,
  output dgr_pkg::sts_t                sts_o,
  input  dgr_pkg::op_e                 in_op_i,
  input  logic [7:0]                   in_from_i,
  input  logic [7:0]                   in_to_i,
  input  logic [7:0]                   in_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output dgr_pkg::status_e             out_status_o
);
  import dgr_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_NODES);
  localparam int unsigned CNT_MAX = (MAX_NODES > INIT_COUNT) ? MAX_NODES : INIT_COUNT;
  localparam int unsigned CW      = $clog2(CNT_MAX + 1);

  op_e                  op_q;
  logic [7:0]           from_q, to_q, nc_q;
  logic [CW-1:0]        count_q;
  logic [MAX_NODES-1:0] row_vld_q;
  logic [AW-1:0]        raddr_q;
  logic [MAX_NODES-1:0] reached_q;
  logic                 changed_q;
  status_e              st_q, st_d;
  logic                 out_vld_q;
  status_e              out_st_q;

  logic [AW-1:0]        r_idx, c_idx, raddr;
  logic                 from_ok, to_ok, nc_ok, is_resize, in_ok;
  logic [MAX_NODES-1:0] rdata, row, col_mask, grow, wdata;
  logic                 edge_bit, hit, chg_now, wr_en, re;

  assign r_idx = AW'(from_q - 8'd1);
  assign c_idx = AW'(to_q - 8'd1);

  assign from_ok = (from_q != 8'd0) && (CMPW'(from_q) <= CMPW'(count_q))
                   && (CMPW'(from_q) <= CMPW'(MAX_NODES));
  assign to_ok   = (to_q != 8'd0) && (CMPW'(to_q) <= CMPW'(count_q))
                   && (CMPW'(to_q) <= CMPW'(MAX_NODES));
  assign nc_ok     = CMPW'(nc_q) <= CMPW'(MAX_NODES);
  assign is_resize = (op_q == OP_RESIZE);
  assign in_ok     = !is_resize && from_ok && to_ok;

  assign re    = cmd_i.rd_row || cmd_i.rd_sweep;
  assign raddr = cmd_i.rd_row ? r_idx : sweep_idx_i;

  // a row not written since the last clear reads as empty
  assign row      = row_vld_q[raddr_q] ? rdata : '0;
  assign col_mask = {{(MAX_NODES-1){1'b0}}, 1'b1} << c_idx;
  assign edge_bit = |(row & col_mask);

  assign hit     = reached_q[raddr_q];
  assign grow    = reached_q | row;
  assign chg_now = hit && (grow != reached_q);

  assign wr_en = cmd_i.row_op && (((op_q == OP_INSERT) && !edge_bit)
                                  || ((op_q == OP_DELETE) && edge_bit));
  assign wdata = (op_q == OP_INSERT) ? (row | col_mask) : (row & ~col_mask);

  dgr_ram #(
    .WIDTH (MAX_NODES),
    .DEPTH (MAX_NODES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (r_idx),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    st_d = st_q;
    if (cmd_i.decode) begin
      if (is_resize) begin
        st_d = nc_ok ? ST_RESIZED : ST_RANGE;
      end else if (!in_ok) begin
        st_d = ST_RANGE;
      end
    end else if (cmd_i.row_op) begin
      case (op_q)
        OP_INSERT: st_d = edge_bit ? ST_DUPLICATE : ST_INSERTED;
        OP_DELETE: st_d = edge_bit ? ST_DELETED : ST_NO_EDGE;
        default:   st_d = st_q;
      endcase
    end else if (cmd_i.trav_done) begin
      st_d = reached_q[c_idx] ? ST_REACHABLE : ST_UNREACHABLE;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      op_q   <= in_op_i;
      from_q <= in_from_i;
      to_q   <= in_to_i;
      nc_q   <= in_count_i;
    end
    if (re) begin
      raddr_q <= raddr;
    end
    if (cmd_i.trav_init) begin
      reached_q <= row;
    end else if (cmd_i.acc && hit) begin
      reached_q <= grow;
    end
    st_q <= st_d;
    if (cmd_i.out_load) begin
      out_st_q <= st_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CW'(INIT_COUNT);
      row_vld_q <= '0;
      changed_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.decode && is_resize && nc_ok) begin
        count_q   <= CW'(nc_q);
        row_vld_q <= '0;
      end else if (wr_en) begin
        row_vld_q[r_idx] <= 1'b1;
      end
      if (cmd_i.trav_init || cmd_i.pass_clr) begin
        changed_q <= 1'b0;
      end else if (cmd_i.acc && chg_now) begin
        changed_q <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.in_ok     = in_ok;
  assign sts_o.is_travel = (op_q == OP_TRAVEL);
  assign sts_o.changed   = changed_q || (cmd_i.acc && chg_now);
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o  = out_vld_q;
  assign out_status_o = out_st_q;

  // edge rows only change for insert or delete
  a_wr_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((op_q == OP_INSERT) || (op_q == OP_DELETE)))
    else $error("edge write outside insert/delete");

  // a good resize leaves every row empty
  a_resize_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.decode && is_resize && nc_ok) |=> (row_vld_q == '0))
    else $error("rows not cleared by resize");

  // the result register is never overwritten while its transfer is pending
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_vld_q || out_ready_i))
    else $error("result overwritten before transfer");

endmodule

### rtl/directed_graph_reachability_table.sv
// ----------------------------------------------------------------------------
// directed_graph_reachability_table: edge matrix with reachability queries
// Top level: stream ports, sequencer and datapath.
// ----------------------------------------------------------------------------
// Usage
//   One operation per input transfer on s_axis_*: insert edge, delete edge,
//   reachability query (one or more edges) or resize-and-clear. Each
//   operation gives exactly one status transfer on m_axis_*, in order.
//   Nodes are numbered 1..count; count is 9 after reset, all edges clear.
// Sequencing
//   resize, out of range : decode, then result
//   insert, delete       : decode with row read, row update, then result
//   query                : decode with row read, then P closure passes,
//                          1 <= P <= MAX_NODES
//   The query time is set by the single read port of the edge RAM: every
//   pass reads each row once, one row per cycle, until a pass adds nothing.
//   One operation is in flight at a time; s_axis_tready is high only while
//   the sequencer is idle, so with the receiver ready the next input can be
//   taken in the same cycle that the result goes valid.
// Reset and stall
//   Reset clears the per-row valid bits, so the edge matrix reads empty at
//   once; no clearing pass. The status sits in an output register: while
//   the receiver stalls, the next operation is still taken and runs up to
//   its own result, which then waits for the register to drain.
// ----------------------------------------------------------------------------
module directed_graph_reachability_table #(
  parameter int unsigned MAX_NODES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] op, [9:2] from_node, [17:10] to_node, [25:18] new_count, [31:26] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [2:0] status, [7:3] zero
  output logic [7:0]  m_axis_tdata
);
  import dgr_pkg::*;

  localparam int unsigned AW = $clog2(MAX_NODES);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] sweep_idx;
  status_e       out_status;

  dgr_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .sweep_idx_o (sweep_idx)
  );

  dgr_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sweep_idx_i  (sweep_idx),
    .sts_o        (sts),
    .in_op_i      (op_e'(s_axis_tdata[1:0])),
    .in_from_i    (s_axis_tdata[9:2]),
    .in_to_i      (s_axis_tdata[17:10]),
    .in_count_i   (s_axis_tdata[25:18]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {5'b0, out_status};

endmodule
